/* hdl/permutation_index_footrule_topk_assert.svh */
// Assertion macros shared by the permutation index RTL.
`ifndef PERMUTATION_INDEX_FOOTRULE_TOPK_ASSERT_SVH
`define PERMUTATION_INDEX_FOOTRULE_TOPK_ASSERT_SVH
// same-cycle implication
`define PIF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define PIF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* hdl/pif_pkg.sv */
// Types and constants of the permutation index footrule search.
`default_nettype none
package pif_pkg;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_OBJECTS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_REFS    = 8'd1;
   localparam logic CMD_BUILD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
   localparam logic [11:0] SCORE_MAX = 12'hFFF;

   typedef struct packed {
      logic       cmd;
      logic [9:0] object_id;
      logic [5:0] rank;
      logic [5:0] ref_id;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [9:0]  best_object;
      logic [11:0] footrule_score;
      logic        final_result;
   } rsp_word_type;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_ACCUM  = 7'b0000100,
      ST_AWAIT  = 7'b0001000,
      ST_SELECT = 7'b0010000,
      ST_SWAIT  = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

/* hdl/permutation_index_footrule_topk.sv */
// Top level of the permutation index footrule top-k search.
// Build words (cmd 0) write the rank table. A query word sweeps the score memory, one object per
// cycle. The last query word adds a selection sweep, which also clears the scores, then
// min(TOP_K, num_objects) result words on consecutive cycles, each shown for one cycle on
// rsp_strobe; the receiver cannot stall. After reset the block clears the score memory with
// busy high; csr writes are taken always.
`default_nettype none
`include "permutation_index_footrule_topk_assert.svh"
module permutation_index_footrule_topk
   import pif_pkg::*;
#(
   parameter int MAX_OBJECTS = 1024,
   parameter int MAX_REFS    = 64,
   parameter int TOP_K       = 10
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  req_word_type           req_word,
   output logic                   rsp_strobe,
   output rsp_word_type           rsp_word,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data
);
   localparam int OW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int OCW = $clog2(MAX_OBJECTS + 1);
   localparam int AW  = $clog2(MAX_REFS * MAX_OBJECTS);
   localparam int RCW = $clog2(MAX_REFS + 1);
   localparam int KW  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
   localparam int KCW = $clog2(TOP_K + 1);

   state_type        state_ff, state_in;
   logic [10:0]      num_objects_ff;
   logic [6:0]       num_refs_ff;
   logic [OCW-1:0]   nobj;
   logic [RCW-1:0]   nref;
   logic [OCW-1:0]   i_ff, i_in;
   logic             last_pend_ff, last_pend_in;
   logic [5:0]       q_rank_ff, q_rank_in;
   logic [AW-1:0]    q_base_ff, q_base_in;
   logic             p_vld_ff, p_sel_ff;
   logic [OW-1:0]    p_idx_ff;
   logic [KW-1:0]    e_ff, e_in;
   logic [KCW-1:0]   cnt_ff, cnt_in;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic [11:0]      sc_ff [TOP_K];
   logic [OW-1:0]    id_ff [TOP_K];

   logic [5:0]       rank_mem [MAX_REFS * MAX_OBJECTS];
   logic [11:0]      acc_mem [MAX_OBJECTS];
   logic [5:0]       rt_q;
   logic [11:0]      acc_q;
   logic             rt_we, acc_we;
   logic [AW-1:0]    rt_wa, rt_ra;
   logic [OW-1:0]    acc_wa, acc_ra;
   logic [11:0]      acc_wd;

   logic             accept, ref_ok, rank_ok, obj_ok, issue, last_i;
   logic [31:0]      wr_addr32, base32;
   logic [5:0]       diff;
   logic [12:0]      sum;
   logic [TOP_K-1:0] gt;

   // effective register values
   always_comb begin
      if (num_objects_ff == 11'd0) nobj = OCW'(1);
      else if (32'(num_objects_ff) > MAX_OBJECTS) nobj = OCW'(MAX_OBJECTS);
      else nobj = OCW'(num_objects_ff);
      if (num_refs_ff == 7'd0) nref = RCW'(1);
      else if (32'(num_refs_ff) > MAX_REFS) nref = RCW'(MAX_REFS);
      else nref = RCW'(num_refs_ff);
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_objects_ff <= 11'd1024;
         num_refs_ff    <= 7'd64;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_OBJECTS: num_objects_ff <= csr_data;
            CSR_NUM_REFS:    num_refs_ff    <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign ref_ok  = 32'(req_word.ref_id) < 32'(nref);
   assign rank_ok = 32'(req_word.rank) < 32'(nref);
   assign obj_ok  = 32'(req_word.object_id) < 32'(nobj);
   assign wr_addr32 = 32'(req_word.ref_id) * MAX_OBJECTS + 32'(req_word.object_id);
   assign base32    = 32'(req_word.ref_id) * MAX_OBJECTS;
   assign issue   = (state_ff == ST_ACCUM) || (state_ff == ST_SELECT);
   assign last_i  = (i_ff == nobj - OCW'(1));

   // rank table port
   assign rt_we = accept && (req_word.cmd == CMD_BUILD) && obj_ok && ref_ok && rank_ok;
   assign rt_wa = wr_addr32[AW-1:0];
   assign rt_ra = q_base_ff + AW'(i_ff);
   always_ff @(posedge clock) begin
      if (rt_we) rank_mem[rt_wa] <= req_word.rank;
      rt_q <= rank_mem[rt_ra];
   end

   // score update
   assign diff = (rt_q > q_rank_ff) ? (rt_q - q_rank_ff) : (q_rank_ff - rt_q);
   assign sum  = {1'b0, acc_q} + 13'(diff);

   // score memory port
   always_comb begin
      acc_we = 1'b0;
      acc_wa = p_idx_ff;
      acc_wd = 12'd0;
      if (state_ff == ST_CLEAR) begin
         acc_we = 1'b1;
         acc_wa = i_ff[OW-1:0];
      end else if (p_vld_ff) begin
         acc_we = 1'b1;
         if (!p_sel_ff) acc_wd = sum[12] ? SCORE_MAX : sum[11:0];
      end
   end
   assign acc_ra = i_ff[OW-1:0];
   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_wa] <= acc_wd;
      acc_q <= acc_mem[acc_ra];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      last_pend_in = last_pend_ff;
      q_rank_in    = q_rank_ff;
      q_base_in    = q_base_ff;
      e_in         = e_ff;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_CLEAR: begin
            i_in = i_ff + OCW'(1);
            if (i_ff == OCW'(MAX_OBJECTS - 1)) begin
               state_in = ST_IDLE;
               i_in     = '0;
            end
         end
         ST_IDLE: begin
            if (accept && (req_word.cmd == CMD_QUERY)) begin
               i_in         = '0;
               last_pend_in = req_word.last;
               q_rank_in    = req_word.rank;
               q_base_in    = base32[AW-1:0];
               if (ref_ok && rank_ok) state_in = ST_ACCUM;
               else if (req_word.last) state_in = ST_SELECT;
            end
         end
         ST_ACCUM: begin
            i_in = i_ff + OCW'(1);
            if (last_i) begin
               i_in     = '0;
               state_in = last_pend_ff ? ST_AWAIT : ST_IDLE;
            end
         end
         ST_AWAIT: state_in = ST_SELECT;
         ST_SELECT: begin
            i_in = i_ff + OCW'(1);
            if (last_i) begin
               i_in     = '0;
               state_in = ST_SWAIT;
            end
         end
         ST_SWAIT: begin
            state_in = ST_EMIT;
            e_in     = '0;
         end
         ST_EMIT: begin
            rsp_word_in.best_object    = 10'(id_ff[e_ff]);
            rsp_word_in.footrule_score = sc_ff[e_ff];
            rsp_word_in.final_result   = ((KCW'(e_ff) + KCW'(1)) == cnt_ff);
            e_in = e_ff + KW'(1);
            if (rsp_word_in.final_result) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ranked list insertion
   always_comb begin
      cnt_in = cnt_ff;
      for (int j = 0; j < TOP_K; j++)
         gt[j] = (KCW'(j) >= cnt_ff) || (sc_ff[j] > acc_q);
      if ((state_ff == ST_IDLE) || (state_ff == ST_AWAIT)) cnt_in = '0;
      else if (p_vld_ff && p_sel_ff && (cnt_ff != KCW'(TOP_K))) cnt_in = cnt_ff + KCW'(1);
   end

   always_ff @(posedge clock) begin
      if (p_vld_ff && p_sel_ff) begin
         for (int j = 0; j < TOP_K; j++) begin
            if (gt[j] && (j == 0 || !gt[(j > 0) ? j - 1 : 0])) begin
               sc_ff[j] <= acc_q;
               id_ff[j] <= p_idx_ff;
            end else if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
               sc_ff[j] <= sc_ff[(j > 0) ? j - 1 : 0];
               id_ff[j] <= id_ff[(j > 0) ? j - 1 : 0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         i_ff         <= '0;
         last_pend_ff <= 1'b0;
         p_vld_ff     <= 1'b0;
         p_sel_ff     <= 1'b0;
         e_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         last_pend_ff <= last_pend_in;
         p_vld_ff     <= issue;
         p_sel_ff     <= (state_ff == ST_SELECT);
         e_ff         <= e_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= (state_ff == ST_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      q_rank_ff   <= q_rank_in;
      q_base_ff   <= q_base_in;
      p_idx_ff    <= i_ff[OW-1:0];
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   `PIF_ASSERT_NXT(a_issue_pipe, clock, reset, issue, p_vld_ff, "read not followed by update")
   `PIF_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= KCW'(TOP_K), "list overfull")
   `PIF_ASSERT_NXT(a_final_ends, clock, reset, rsp_valid_ff && rsp_word_ff.final_result, !rsp_valid_ff, "word after final")
   `PIF_ASSERT_IMP(a_strobe_src, clock, reset, rsp_valid_ff, $past(state_ff) == ST_EMIT, "stray result word")
endmodule
`default_nettype wire
